// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent on this edge implies consequent on the same edge
`define AST_IMPLIES(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");

// condition must never hold out of reset
`define AST_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("assertion failed");

`endif

// ===== rtl/ftls_pkg.sv =====
// shared types and constants for the throttle link supervisor
package ftls_pkg;

    localparam int RXB_W      = 8;
    localparam int TIME_W     = 32;
    localparam int POS_W      = 4;
    localparam int PAYLOAD_W  = 64;
    localparam int THR_W      = 11;
    localparam int NUM_THR    = 4;
    localparam int MIN_W      = 6;
    localparam int TIMEOUT_W  = 16;
    localparam int HOLD_W     = 8;
    localparam int STARTUP_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 48;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [RXB_W-1:0] HDR0 = 8'hAB;
    localparam logic [RXB_W-1:0] HDR1 = 8'hCD;
    localparam logic [POS_W-1:0] POS_HDR1      = 4'd1;
    localparam logic [POS_W-1:0] POS_FIRST_PL  = 4'd2;
    localparam logic [POS_W-1:0] POS_SUM_LO    = 4'd10;
    localparam logic [POS_W-1:0] POS_LAST      = 4'd11;

    localparam logic [MIN_W-1:0]     MIN_THROTTLE_RST = 6'd48;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST      = 16'd100;
    localparam logic [HOLD_W-1:0]    HOLD_RST         = 8'd33;
    localparam logic [STARTUP_W-1:0] STARTUP_RST      = 16'd3000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_THROTTLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESYNC_HOLD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP      = 2'd3;

    // input item kinds carried in s_tuser
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // work handed from the front to the back for each tick
    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic                 live;
        logic                 apply;
        logic                 link_up;
    } tick_cmd_t;

    typedef struct packed {
        logic not_full;
        logic not_empty;
    } queue_stat_t;

endpackage

// ===== rtl/framed_throttle_link_supervisor.sv =====
// top level: config registers, front end, command queue and back end
// one item accepted per cycle while the command queue has room; bytes give no result
// a tick's result is written into a queue entry at its transfer, then into the output
// register that drives m_tdata when the back end pops it
// s_tready drops only while the command queue is full under output back-pressure
// aresetn is synchronous, active low: clears link state, queue, drive values, loads defaults
`include "assert_macros.svh"
module framed_throttle_link_supervisor import ftls_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_DATA_W-1:0]    s_tdata,   // rx_byte[7:0], now_ms[39:8]
    input  logic                   s_tuser,   // operation
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_DATA_W-1:0]    m_tdata,   // throttle_a..d [43:0], link_up, applied
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    logic [MIN_W-1:0]     min_throttle_reg;
    logic [TIMEOUT_W-1:0] link_timeout_reg;
    logic [HOLD_W-1:0]    resync_hold_reg;
    logic [STARTUP_W-1:0] startup_delay_reg;

    queue_stat_t q_stat;
    logic        push, pop;
    tick_cmd_t   push_cmd, head_cmd;
    logic        tick_xfer;

    assign tick_xfer = s_tvalid && s_tready && (s_tuser == OP_TICK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_throttle_reg  <= MIN_THROTTLE_RST;
            link_timeout_reg  <= TIMEOUT_RST;
            resync_hold_reg   <= HOLD_RST;
            startup_delay_reg <= STARTUP_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MIN_THROTTLE: min_throttle_reg  <= cfg_wdata[MIN_W-1:0];
                CFG_LINK_TIMEOUT: link_timeout_reg  <= cfg_wdata[TIMEOUT_W-1:0];
                CFG_RESYNC_HOLD:  resync_hold_reg   <= cfg_wdata[HOLD_W-1:0];
                CFG_STARTUP:      startup_delay_reg <= cfg_wdata[STARTUP_W-1:0];
                default: ;
            endcase
        end
    end

    ftls_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .link_timeout_ms  (link_timeout_reg),
        .resync_hold_ms   (resync_hold_reg),
        .startup_delay_ms (startup_delay_reg),
        .q_stat           (q_stat),
        .push             (push),
        .push_cmd         (push_cmd)
    );

    ftls_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    ftls_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .min_throttle (min_throttle_reg),
        .q_stat       (q_stat),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    // a tick transfer always finds room in the queue
    `AST_IMPLIES(a_tick_has_room, aclk, aresetn, tick_xfer, q_stat.not_full)
    // an applied result only comes with the link up
    `AST_IMPLIES(a_applied_link_up, aclk, aresetn, m_tvalid && m_tdata[45], m_tdata[44])
    // with the link down every drive value reads zero
    `AST_IMPLIES(a_down_is_zero, aclk, aresetn, m_tvalid && !m_tdata[44], m_tdata[43:0] == '0)
    // a popped apply command always carries a live link
    `AST_NEVER(a_apply_is_live, aclk, aresetn, head_cmd.apply && !head_cmd.live && pop)

endmodule

// ===== rtl/ftls_front.sv =====
// front end: frame assembly, link state and tick decisions
module ftls_front import ftls_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  s_tuser,
    input  logic [TIMEOUT_W-1:0]  link_timeout_ms,
    input  logic [HOLD_W-1:0]     resync_hold_ms,
    input  logic [STARTUP_W-1:0]  startup_delay_ms,
    input  queue_stat_t           q_stat,
    output logic                  push,
    output tick_cmd_t             push_cmd
);

    logic [POS_W-1:0]     byte_pos_reg, byte_pos_next;
    logic                 header_good_reg, header_good_next;
    logic [15:0]          running_sum_reg, running_sum_next;
    logic [7:0]           sum_low_reg, sum_low_next;
    logic [PAYLOAD_W-1:0] incoming_reg, incoming_next;
    logic [PAYLOAD_W-1:0] latched_reg, latched_next;
    logic                 connected_reg, connected_next;
    logic                 started_reg, started_next;
    logic                 pending_reg, pending_next;
    logic [TIME_W-1:0]    last_good_reg, last_good_next;
    logic                 holding_reg, holding_next;
    logic [TIME_W-1:0]    hold_start_reg, hold_start_next;

    logic                 accept;
    logic [RXB_W-1:0]     rx_byte;
    logic [TIME_W-1:0]    now_ms;
    logic                 take;
    logic [POS_W-1:0]     pos;
    logic [2:0]           lane;
    logic                 good;
    logic                 conn_tick;
    logic                 live;

    assign s_tready = q_stat.not_full;
    assign accept   = s_tvalid && s_tready;
    assign rx_byte  = s_tdata[RXB_W-1:0];
    assign now_ms   = s_tdata[RXB_W +: TIME_W];
    assign lane     = 3'(pos - POS_FIRST_PL);

    always_comb begin
        byte_pos_next    = byte_pos_reg;
        header_good_next = header_good_reg;
        running_sum_next = running_sum_reg;
        sum_low_next     = sum_low_reg;
        incoming_next    = incoming_reg;
        latched_next     = latched_reg;
        connected_next   = connected_reg;
        started_next     = started_reg;
        pending_next     = pending_reg;
        last_good_next   = last_good_reg;
        holding_next     = holding_reg;
        hold_start_next  = hold_start_reg;
        take             = 1'b0;
        pos              = byte_pos_reg;
        good             = 1'b0;
        conn_tick        = connected_reg;
        live             = 1'b0;
        push             = 1'b0;
        push_cmd         = '0;

        if (accept && s_tuser == OP_BYTE) begin
            take = 1'b1;
            if (holding_reg) begin
                if ((now_ms - hold_start_reg) < TIME_W'(resync_hold_ms)) begin
                    take = 1'b0;
                end else begin
                    holding_next = 1'b0;
                    pos          = '0;
                end
            end
            if (take) begin
                if (pos == '0) begin
                    header_good_next = (rx_byte == HDR0);
                    running_sum_next = '0;
                    incoming_next    = '0;
                end else if (pos == POS_HDR1) begin
                    header_good_next = header_good_reg && (rx_byte == HDR1);
                end else if (pos < POS_SUM_LO) begin
                    running_sum_next = running_sum_reg + 16'(rx_byte);
                    incoming_next[{lane, 3'b000} +: RXB_W] = rx_byte;
                end else if (pos == POS_SUM_LO) begin
                    sum_low_next = rx_byte;
                end

                if (pos < POS_LAST) begin
                    byte_pos_next = pos + 1'b1;
                end else begin
                    // end of frame: check header and sum
                    byte_pos_next = '0;
                    good = header_good_next && (running_sum_next == {rx_byte, sum_low_next});
                    if (!connected_reg) begin
                        if (good) begin
                            latched_next   = incoming_next;
                            last_good_next = now_ms;
                            connected_next = 1'b1;
                        end else begin
                            holding_next    = 1'b1;
                            hold_start_next = now_ms;
                        end
                    end else if (good) begin
                        latched_next   = incoming_next;
                        pending_next   = 1'b1;
                        last_good_next = now_ms;
                    end else begin
                        connected_next = 1'b0;
                    end
                end
            end
        end else if (accept && s_tuser == OP_TICK) begin
            if (connected_reg && ((now_ms - last_good_reg) > TIME_W'(link_timeout_ms))) begin
                conn_tick = 1'b0;
            end
            connected_next = conn_tick;
            if (now_ms > TIME_W'(startup_delay_ms)) begin
                started_next = 1'b1;
            end
            live = conn_tick && started_next;
            if (live && pending_reg) begin
                pending_next = 1'b0;
            end
            push             = 1'b1;
            push_cmd.payload = latched_reg;
            push_cmd.live    = live;
            push_cmd.apply   = live && pending_reg;
            push_cmd.link_up = conn_tick;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg    <= '0;
            header_good_reg <= 1'b0;
            running_sum_reg <= '0;
            sum_low_reg     <= '0;
            incoming_reg    <= '0;
            latched_reg     <= '0;
            connected_reg   <= 1'b0;
            started_reg     <= 1'b0;
            pending_reg     <= 1'b0;
            last_good_reg   <= '0;
            holding_reg     <= 1'b0;
            hold_start_reg  <= '0;
        end else begin
            byte_pos_reg    <= byte_pos_next;
            header_good_reg <= header_good_next;
            running_sum_reg <= running_sum_next;
            sum_low_reg     <= sum_low_next;
            incoming_reg    <= incoming_next;
            latched_reg     <= latched_next;
            connected_reg   <= connected_next;
            started_reg     <= started_next;
            pending_reg     <= pending_next;
            last_good_reg   <= last_good_next;
            holding_reg     <= holding_next;
            hold_start_reg  <= hold_start_next;
        end
    end

endmodule

// ===== rtl/ftls_queue.sv =====
// short command queue between the front and the back
module ftls_queue import ftls_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  tick_cmd_t   push_cmd,
    input  logic        pop,
    output tick_cmd_t   head_cmd,
    output queue_stat_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    tick_cmd_t         entries [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign q_stat.not_full  = (count_reg != FULL_CNT);
    assign q_stat.not_empty = (count_reg != '0);
    assign do_push  = push && q_stat.not_full;
    assign do_pop   = pop && q_stat.not_empty;
    assign head_cmd = entries[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/ftls_back.sv =====
// back end: throttle scaling, drive values and output register
module ftls_back import ftls_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [MIN_W-1:0]     min_throttle,
    input  queue_stat_t          q_stat,
    input  tick_cmd_t            head_cmd,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata
);

    // clamp to 1000, zero stays zero, else min + floor((v-1)*1999/999) = min + 2u + (u == 999)
    function automatic logic [THR_W-1:0] scale_thr(input logic [15:0] raw,
                                                   input logic [MIN_W-1:0] base);
        logic [9:0]  clamped;
        logic [9:0]  u;
        logic [11:0] sum;
        begin
            clamped = (raw > 16'd1000) ? 10'd1000 : raw[9:0];
            u       = clamped - 10'd1;
            sum     = 12'(base) + {1'b0, u, 1'b0} + 12'(u == 10'd999);
            scale_thr = (clamped == '0) ? '0 : sum[THR_W-1:0];
        end
    endfunction

    logic [THR_W-1:0]    drive_reg [NUM_THR];
    logic [THR_W-1:0]    drive_next [NUM_THR];
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    assign pop      = q_stat.not_empty && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        for (int i = 0; i < NUM_THR; i++) begin
            drive_next[i] = drive_reg[i];
            if (pop) begin
                if (!head_cmd.live) begin
                    drive_next[i] = '0;
                end else if (head_cmd.apply) begin
                    drive_next[i] = scale_thr(head_cmd.payload[16*i +: 16], min_throttle);
                end
            end
        end
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (pop) begin
            m_valid_next = 1'b1;
            m_data_next  = {2'b00, head_cmd.apply, head_cmd.link_up,
                            drive_next[3], drive_next[2], drive_next[1], drive_next[0]};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_THR; i++) begin
                drive_reg[i] <= '0;
            end
        end else begin
            m_valid_reg <= m_valid_next;
            for (int i = 0; i < NUM_THR; i++) begin
                drive_reg[i] <= drive_next[i];
            end
        end
    end

endmodule

// ===== tb/sv/framed_throttle_link_supervisor_test.sv =====
// testbench for the throttle link supervisor: directed frames, then random traffic per setting
module framed_throttle_link_supervisor_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ftls_pkg::*;

    localparam int CLAMP_TOP = 1000;
    localparam int SPAN_NUM  = 1999;
    localparam int SPAN_DEN  = 999;
    localparam int PHASES    = 6;
    localparam int PHASE_ITEMS = 275;

    typedef struct packed {
        logic             applied;
        logic             link_up;
        logic [THR_W-1:0] thr_d;
        logic [THR_W-1:0] thr_c;
        logic [THR_W-1:0] thr_b;
        logic [THR_W-1:0] thr_a;
    } tick_report_t;

    typedef struct {
        logic               op;
        logic [RXB_W-1:0]   rx;
        logic [TIME_W-1:0]  now;
        bit                 typed;
        tick_report_t       want;
    } stim_t;

    typedef struct {
        logic [MIN_W-1:0]     min_thr;
        logic [TIMEOUT_W-1:0] timeout;
        logic [HOLD_W-1:0]    hold;
        logic [STARTUP_W-1:0] startup;
    } settings_t;

    typedef logic [RXB_W-1:0] frame_t [12];

    typedef enum int {FLAW_NONE, FLAW_HDR0, FLAW_HDR1, FLAW_BODY, FLAW_SUM, FLAW_SHORT} flaw_e;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  s_tuser = OP_BYTE;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_MIN_THROTTLE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    framed_throttle_link_supervisor DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // supervisor state as predicted
    logic [MIN_W-1:0]     cfg_min;
    logic [TIMEOUT_W-1:0] cfg_timeout;
    logic [HOLD_W-1:0]    cfg_hold;
    logic [STARTUP_W-1:0] cfg_startup;
    logic [POS_W-1:0]     fr_pos;
    bit                   hdr_ok;
    logic [15:0]          pay_sum;
    logic [RXB_W-1:0]     sum_lo;
    logic [PAYLOAD_W-1:0] rx_payload;
    logic [PAYLOAD_W-1:0] held_payload;
    logic [THR_W-1:0]     drive_now [NUM_THR];
    bit                   link_on;
    bit                   start_done;
    bit                   upd_pending;
    logic [TIME_W-1:0]    last_good_ms;
    bit                   in_hold;
    logic [TIME_W-1:0]    hold_from_ms;

    tick_report_t  pending_reports [$];
    stim_t         bring_up_rows [$];
    int            fault_count = 0;
    int            work_items = 0;
    int            burst_left = 5;
    logic [TIME_W-1:0] stamp_ms = '0;
    int            stall_left = 0;
    int            stall_mode = 0;
    tick_report_t  got;

    task automatic reset_model();
        cfg_min      = MIN_THROTTLE_RST;
        cfg_timeout  = TIMEOUT_RST;
        cfg_hold     = HOLD_RST;
        cfg_startup  = STARTUP_RST;
        fr_pos       = '0;
        hdr_ok       = 1'b0;
        pay_sum      = '0;
        sum_lo       = '0;
        rx_payload   = '0;
        held_payload = '0;
        drive_now    = '{default: '0};
        link_on      = 1'b0;
        start_done   = 1'b0;
        upd_pending  = 1'b0;
        last_good_ms = '0;
        in_hold      = 1'b0;
        hold_from_ms = '0;
    endtask

    // returns 0 when the byte falls inside the resync hold and is dropped
    function automatic bit supervise_byte(input logic [RXB_W-1:0] b, input logic [TIME_W-1:0] now);
        logic [POS_W-1:0]  pos;
        logic [TIME_W-1:0] since;
        bit                good;
        pos = fr_pos;
        if (in_hold) begin
            since = now - hold_from_ms;
            if (since < {24'd0, cfg_hold})
                return 1'b0;
            in_hold = 1'b0;
            pos = '0;
        end
        if (pos == 0) begin
            hdr_ok = (b == HDR0);
            pay_sum = '0;
            rx_payload = '0;
        end else if (pos == POS_HDR1) begin
            hdr_ok = hdr_ok && (b == HDR1);
        end else if (pos < POS_SUM_LO) begin
            pay_sum = pay_sum + 16'(b);
            rx_payload[8*(pos-POS_FIRST_PL) +: 8] = b;
        end else if (pos == POS_SUM_LO) begin
            sum_lo = b;
        end
        if (pos < POS_LAST) begin
            fr_pos = pos + 1'b1;
            return 1'b1;
        end
        fr_pos = '0;
        good = hdr_ok && (pay_sum == {b, sum_lo});
        if (!link_on) begin
            if (good) begin
                held_payload = rx_payload;
                last_good_ms = now;
                link_on = 1'b1;
            end else begin
                in_hold = 1'b1;
                hold_from_ms = now;
            end
        end else if (good) begin
            held_payload = rx_payload;
            upd_pending = 1'b1;
            last_good_ms = now;
        end else begin
            link_on = 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic tick_report_t supervise_tick(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] since;
        int                v;
        tick_report_t      rep;
        rep = '0;
        since = now - last_good_ms;
        if (link_on && since > {16'd0, cfg_timeout})
            link_on = 1'b0;
        if (!start_done && now > {16'd0, cfg_startup})
            start_done = 1'b1;
        if (link_on && start_done) begin
            if (upd_pending) begin
                upd_pending = 1'b0;
                for (int i = 0; i < NUM_THR; i++) begin
                    v = int'(held_payload[16*i +: 16]);
                    if (v > CLAMP_TOP)
                        v = CLAMP_TOP;
                    if (v > 0)
                        v = int'(cfg_min) + ((v - 1) * SPAN_NUM) / SPAN_DEN;
                    drive_now[i] = THR_W'(v);
                end
                rep.applied = 1'b1;
            end
        end else begin
            drive_now = '{default: '0};
        end
        rep.thr_a = drive_now[0];
        rep.thr_b = drive_now[1];
        rep.thr_c = drive_now[2];
        rep.thr_d = drive_now[3];
        rep.link_up = link_on;
        return rep;
    endfunction

    function automatic tick_report_t report(input int a, b, c, d, input bit up, done);
        tick_report_t rep;
        rep.thr_a = THR_W'(a);
        rep.thr_b = THR_W'(b);
        rep.thr_c = THR_W'(c);
        rep.thr_d = THR_W'(d);
        rep.link_up = up;
        rep.applied = done;
        return rep;
    endfunction

    function automatic stim_t make_row(input logic op, input logic [RXB_W-1:0] rx,
                                       input logic [TIME_W-1:0] now, input bit typed,
                                       input tick_report_t want);
        stim_t row;
        row.op = op;
        row.rx = rx;
        row.now = now;
        row.typed = typed;
        row.want = want;
        return row;
    endfunction

    function automatic frame_t build_frame(input logic [PAYLOAD_W-1:0] payload);
        frame_t      f;
        logic [15:0] sum;
        sum = '0;
        f[0] = HDR0;
        f[1] = HDR1;
        for (int i = 0; i < 8; i++) begin
            f[2+i] = payload[8*i +: 8];
            sum = sum + 16'(payload[8*i +: 8]);
        end
        f[10] = sum[7:0];
        f[11] = sum[15:8];
        return f;
    endfunction

    function automatic logic [15:0] pick_throttle();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'd1000;
            3: return 16'd1001;
            4: return 16'hFFFF;
            5: return 16'($urandom_range(2, 999));
            default: return 16'($urandom());
        endcase
    endfunction

    // one transfer on the input side, then maybe a gap before the next burst
    task automatic send_item(input stim_t it);
        tick_report_t rep;
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {it.now, it.rx};
        do @(posedge aclk); while (!s_tready);
        if (it.op == OP_BYTE) begin
            if (supervise_byte(it.rx, it.now))
                work_items++;
        end else begin
            rep = supervise_tick(it.now);
            pending_reports.push_back(it.typed ? it.want : rep);
            work_items++;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(0, 25);
        end
    endtask

    task automatic send_byte(input logic [RXB_W-1:0] b);
        // sometimes land right on the edge of the discard window
        if (in_hold && $urandom_range(0, 3) == 0)
            stamp_ms = hold_from_ms + TIME_W'(cfg_hold) - $urandom_range(0, 1);
        else
            stamp_ms = stamp_ms + $urandom_range(0, 2);
        send_item(make_row(OP_BYTE, b, stamp_ms, 1'b0, '0));
    endtask

    task automatic send_tick();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            stamp_ms = stamp_ms;
        else if (pick < 75)
            stamp_ms = stamp_ms + $urandom_range(1, 25);
        else if (pick < 92 && link_on)
            stamp_ms = last_good_ms + TIME_W'(cfg_timeout) + $urandom_range(0, 1);
        else if (pick < 96)
            stamp_ms = stamp_ms + $urandom_range(100, 70000);
        else if (pick < 98)
            stamp_ms = 32'hFFFF_FFF0 + $urandom_range(0, 15);
        else
            stamp_ms = $urandom();
        send_item(make_row(OP_TICK, 8'($urandom_range(0, 255)), stamp_ms, 1'b0, '0));
    endtask

    task automatic send_frame(input flaw_e flaw);
        logic [PAYLOAD_W-1:0] payload;
        frame_t               f;
        int                   n;
        for (int i = 0; i < NUM_THR; i++)
            payload[16*i +: 16] = pick_throttle();
        f = build_frame(payload);
        n = 12;
        case (flaw)
            FLAW_HDR0:  f[0] ^= 8'($urandom_range(1, 255));
            FLAW_HDR1:  f[1] ^= 8'($urandom_range(1, 255));
            FLAW_BODY:  f[$urandom_range(2, 9)] ^= 8'($urandom_range(1, 255));
            FLAW_SUM:   f[$urandom_range(10, 11)] ^= 8'($urandom_range(1, 255));
            FLAW_SHORT: n = $urandom_range(1, 11);
            default: ;
        endcase
        for (int i = 0; i < n; i++)
            send_byte(f[i]);
    endtask

    task automatic random_traffic(input int count);
        int goal;
        int pick;
        goal = work_items + count;
        while (work_items < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_frame(FLAW_NONE);
            else if (pick < 72)
                send_frame(flaw_e'($urandom_range(FLAW_HDR0, FLAW_SUM)));
            else if (pick < 80)
                send_frame(FLAW_SHORT);
            else if (pick < 90)
                repeat ($urandom_range(1, 14))
                    send_byte(($urandom_range(0, 5) == 0) ? HDR0 : 8'($urandom_range(0, 255)));
            else
                stamp_ms = stamp_ms + $urandom_range(0, 400);
            repeat ($urandom_range(0, 3))
                send_tick();
        end
    endtask

    // drain every tick report, then let the input side idle before going on
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_settings(input settings_t s);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        idx = '{CFG_MIN_THROTTLE, CFG_LINK_TIMEOUT, CFG_RESYNC_HOLD, CFG_STARTUP};
        val = '{16'(s.min_thr), s.timeout, 16'(s.hold), s.startup};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        cfg_min     = s.min_thr;
        cfg_timeout = s.timeout;
        cfg_hold    = s.hold;
        cfg_startup = s.startup;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] actual);
        if (actual !== want) begin
            $error("%s expected %0d got %0d", name, want, actual);
            fault_count++;
        end
    endtask

    // receiver: stalls in modes of random length, checks each result transfer
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(5, 60);
        end else begin
            stall_left = stall_left - 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 2) != 0);
            default: m_tready <= ($urandom_range(0, 11) == 0);
        endcase
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(tick_report_t)-1:0];
            if (pending_reports.size() == 0) begin
                $error("tick report transfer with none expected");
                fault_count++;
            end else begin
                check_field("throttle_a", 32'(pending_reports[0].thr_a), 32'(got.thr_a));
                check_field("throttle_b", 32'(pending_reports[0].thr_b), 32'(got.thr_b));
                check_field("throttle_c", 32'(pending_reports[0].thr_c), 32'(got.thr_c));
                check_field("throttle_d", 32'(pending_reports[0].thr_d), 32'(got.thr_d));
                check_field("link_up", 32'(pending_reports[0].link_up), 32'(got.link_up));
                check_field("applied", 32'(pending_reports[0].applied), 32'(got.applied));
                void'(pending_reports.pop_front());
            end
        end
    end

    initial begin
        frame_t    f;
        settings_t s;
        reset_model();

        // bring-up: first frame connects before startup, second one applies the extremes
        bring_up_rows.push_back(make_row(OP_TICK, 8'hFF, 32'd0, 1'b1, report(0, 0, 0, 0, 0, 0)));
        f = build_frame({16'hFFFF, 16'd1000, 16'd1, 16'd0});
        for (int i = 0; i < 12; i++)
            bring_up_rows.push_back(make_row(OP_BYTE, f[i], 32'd3000, 1'b0, '0));
        bring_up_rows.push_back(make_row(OP_TICK, 8'h5A, 32'd3000, 1'b1,
                                         report(0, 0, 0, 0, 1, 0)));
        for (int i = 0; i < 12; i++)
            bring_up_rows.push_back(make_row(OP_BYTE, f[i], 32'd3001, 1'b0, '0));
        bring_up_rows.push_back(make_row(OP_TICK, 8'hA5, 32'd3001, 1'b1,
                                         report(0, 48, 2047, 2047, 1, 1)));
        // huge elapsed time drops the link
        bring_up_rows.push_back(make_row(OP_TICK, 8'h00, 32'hFFFF_FFFF, 1'b1,
                                         report(0, 0, 0, 0, 0, 0)));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (bring_up_rows[i])
            send_item(bring_up_rows[i]);
        stamp_ms = 32'd5000;

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                settle();
                if (phase == 1)
                    s = '{6'd0, 16'hFFFF, 8'hFF, 16'd0};
                else if (phase == 2)
                    s = '{6'd48, 16'd0, 8'd0, 16'hFFFF};
                else
                    s = '{6'($urandom_range(0, 48)),
                          ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 150)),
                          8'($urandom_range(0, 255)),
                          16'($urandom())};
                write_settings(s);
            end
            random_traffic(PHASE_ITEMS);
        end

        settle();
        repeat (10) @(posedge aclk);
        if (fault_count == 0)
            $display("framed_throttle_link_supervisor test passed");
        else
            $display("framed_throttle_link_supervisor test failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("framed_throttle_link_supervisor test failed");
        $finish;
    end

endmodule

// ===== framed_throttle_link_supervisor.f =====
+incdir+rtl
rtl/ftls_pkg.sv
rtl/ftls_front.sv
rtl/ftls_queue.sv
rtl/ftls_back.sv
rtl/framed_throttle_link_supervisor.sv
tb/sv/framed_throttle_link_supervisor_test.sv
